[src/cmvr_pkg.sv]
// Shared types and register codes for the range clip with minimum valid run.
// No dependencies; every other file of the block imports it.
package cmvr_pkg;

  typedef logic signed [15:0] sample_t;
  typedef logic [2:0]         cfg_idx_t;
  typedef logic [15:0]        cfg_data_t;

  // Register indexes of the configuration port
  localparam cfg_idx_t REG_MIN_RUN    = 3'd0;
  localparam cfg_idx_t REG_LOW_LIMIT  = 3'd1;
  localparam cfg_idx_t REG_HIGH_LIMIT = 3'd2;
  localparam cfg_idx_t REG_LOW_FILL   = 3'd3;
  localparam cfg_idx_t REG_HIGH_FILL  = 3'd4;

  localparam int MIN_RUN_W = 6;

  // Control handed to every cell of the sample chain
  typedef struct packed {
    logic    load;
    logic    shift;
    sample_t din;
  } chain_ctl_t;

endpackage

[src/cmvr_if.sv]
// Handshake channels of the block: sample input, result output, register write.
// Depends on cmvr_pkg for the payload types.
interface cmvr_in_if import cmvr_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample_in;
  logic    not_a_number;
  logic    record_end;

  modport source (output valid, sample_in, not_a_number, record_end, input ready);
  modport sink   (input valid, sample_in, not_a_number, record_end, output ready);
endinterface

interface cmvr_out_if import cmvr_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample_out;
  logic    last_of_burst;
  logic    record_done;

  modport source (output valid, sample_out, last_of_burst, record_done, input ready);
  modport sink   (input valid, sample_out, last_of_burst, record_done, output ready);
endinterface

interface cmvr_cfg_if import cmvr_pkg::*; ();
  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_data_t data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[src/cmvr_cell.sv]
// One cell of the held-sample chain: loads a new word or takes its neighbor's.
// Depends on cmvr_pkg.
module cmvr_cell import cmvr_pkg::*; (
  input  logic       clk,
  input  chain_ctl_t ctl,
  input  logic       sel,
  input  sample_t    nbr,
  output sample_t    q
);

  sample_t q_r;

  // Load wins over shift so a new word can enter while the chain drains
  always_ff @(posedge clk) begin
    if (ctl.load && sel) begin
      q_r <= ctl.din;
    end else if (ctl.shift) begin
      q_r <= nbr;
    end
  end

  assign q = q_r;

endmodule

[src/cmvr_chain.sv]
// Row of cmvr_cell instances; words are written at a slot and drain toward slot 0.
// Depends on cmvr_pkg and cmvr_cell.
module cmvr_chain import cmvr_pkg::*; #(
  parameter int MAX_RUN = 32,
  parameter int CNT_W   = $clog2(MAX_RUN + 1)
) (
  input  logic             clk,
  input  chain_ctl_t       ctl,
  input  logic [CNT_W-1:0] load_idx,
  output sample_t          head
);

  sample_t q [MAX_RUN];

  for (genvar i = 0; i < MAX_RUN; i++) begin : g_cell
    sample_t nbr;
    logic    sel;

    // Last cell keeps its own word on a shift
    if (i == MAX_RUN - 1) begin : g_tail
      assign nbr = q[i];
    end else begin : g_mid
      assign nbr = q[i+1];
    end

    assign sel = (load_idx == CNT_W'(i));

    cmvr_cell u_cell (
      .clk (clk),
      .ctl (ctl),
      .sel (sel),
      .nbr (nbr),
      .q   (q[i])
    );
  end

  assign head = q[0];

endmodule

[src/clip_with_min_valid_run_core.sv]
// Range clip with minimum valid run: top level with classifier, run control and output.
// Depends on cmvr_pkg, cmvr_if and cmvr_chain.
//
// Each input word is classed low (below low_limit or flagged not a number), high (above
// high_limit) or in range. In-range words of a run shorter than min_run_length (capped at
// MAX_RUN) are held in a chain of MAX_RUN cells; they leave unchanged once the run reaches
// the minimum or the record ends, or as low_fill/high_fill when a low or high word follows.
// A word that passes or is clipped with nothing held goes out alone; the block then
// sustains one word per cycle unless stalled. A word that releases k held words produces
// a burst of k+1 result words, one per cycle unless stalled, from the head cell of the
// chain into the output register; the next input word is taken in the cycle the last
// burst word moves out. A held word produces no result. No clearing pass follows reset.
module clip_with_min_valid_run_core import cmvr_pkg::*; #(
  parameter int MAX_RUN = 32
) (
  input  logic clk,
  input  logic rst_n,
  cmvr_in_if.sink    in_s,
  cmvr_out_if.source out_m,
  cmvr_cfg_if.sink   cfg_s
);

  localparam int CNT_W = $clog2(MAX_RUN + 1);
  localparam int CMP_W = ((CNT_W > MIN_RUN_W) ? CNT_W : MIN_RUN_W) + 1;

  // Configuration registers
  logic [MIN_RUN_W-1:0] min_run_r;
  sample_t              low_limit_r;
  sample_t              high_limit_r;
  sample_t              low_fill_r;
  sample_t              high_fill_r;

  // Run and burst state
  logic             passing_r,    passing_nxt;
  logic [CNT_W-1:0] run_count_r,  run_count_nxt;
  logic [CNT_W-1:0] drain_left_r, drain_left_nxt;
  logic             burst_fill_r;
  sample_t          burst_fill_val_r;
  logic             burst_rec_end_r;

  // Output register
  logic    out_valid_r;
  sample_t out_sample_r;
  logic    out_last_r;
  logic    out_done_r;

  logic       in_fire;
  logic       can_move;
  logic       drain_fire;
  logic       is_low;
  logic       is_high;
  logic       release_run;
  logic       start_drain;
  logic [CMP_W-1:0] m_eff;
  logic [CMP_W-1:0] cnt_inc;
  chain_ctl_t ctl;
  sample_t    head;

  // Register writes are always taken
  assign cfg_s.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_run_r    <= '0;
      low_limit_r  <= 16'sh8000;
      high_limit_r <= 16'sh7FFF;
      low_fill_r   <= '0;
      high_fill_r  <= '0;
    end else if (cfg_s.valid) begin
      unique case (cfg_s.index)
        REG_MIN_RUN:    min_run_r    <= cfg_s.data[MIN_RUN_W-1:0];
        REG_LOW_LIMIT:  low_limit_r  <= cfg_s.data;
        REG_HIGH_LIMIT: high_limit_r <= cfg_s.data;
        REG_LOW_FILL:   low_fill_r   <= cfg_s.data;
        REG_HIGH_FILL:  high_fill_r  <= cfg_s.data;
        default: ;
      endcase
    end
  end

  // Drain one burst word whenever the output register is free
  assign can_move   = !out_valid_r || out_m.ready;
  assign drain_fire = (drain_left_r != '0) && can_move;
  assign in_s.ready = (drain_left_r == '0) || ((drain_left_r == CNT_W'(1)) && can_move);
  assign in_fire    = in_s.valid && in_s.ready;

  // Classify the incoming word; low wins when both limits are crossed
  assign is_low  = in_s.not_a_number || (in_s.sample_in < low_limit_r);
  assign is_high = !is_low && (in_s.sample_in > high_limit_r);

  assign m_eff   = (CMP_W'(min_run_r) > CMP_W'(MAX_RUN)) ? CMP_W'(MAX_RUN) : CMP_W'(min_run_r);
  assign cnt_inc = CMP_W'(run_count_r) + CMP_W'(1);
  assign release_run = passing_r || (cnt_inc >= m_eff);
  assign start_drain = is_low || is_high || release_run || in_s.record_end;

  // Append every accepted word at the end of the held run
  always_comb begin
    ctl.load  = in_fire;
    ctl.shift = drain_fire;
    ctl.din   = in_s.sample_in;
  end

  cmvr_chain #(
    .MAX_RUN (MAX_RUN),
    .CNT_W   (CNT_W)
  ) u_chain (
    .clk      (clk),
    .ctl      (ctl),
    .load_idx (run_count_r),
    .head     (head)
  );

  // Next run state and burst length
  always_comb begin
    passing_nxt    = passing_r;
    run_count_nxt  = run_count_r;
    drain_left_nxt = drain_fire ? drain_left_r - CNT_W'(1) : drain_left_r;
    if (in_fire) begin
      if (is_low || is_high) begin
        passing_nxt   = 1'b0;
        run_count_nxt = '0;
      end else if (release_run) begin
        passing_nxt   = 1'b1;
        run_count_nxt = '0;
      end else begin
        run_count_nxt = run_count_r + CNT_W'(1);
      end
      if (in_s.record_end) begin
        passing_nxt   = 1'b0;
        run_count_nxt = '0;
      end
      if (start_drain) begin
        drain_left_nxt = run_count_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      passing_r    <= 1'b0;
      run_count_r  <= '0;
      drain_left_r <= '0;
    end else begin
      passing_r    <= passing_nxt;
      run_count_r  <= run_count_nxt;
      drain_left_r <= drain_left_nxt;
    end
  end

  // Latch how the burst is to be emitted
  always_ff @(posedge clk) begin
    if (in_fire && start_drain) begin
      burst_fill_r     <= is_low || is_high;
      burst_fill_val_r <= is_low ? low_fill_r : high_fill_r;
      burst_rec_end_r  <= in_s.record_end;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (drain_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_m.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (drain_fire) begin
      out_sample_r <= burst_fill_r ? burst_fill_val_r : head;
      out_last_r   <= (drain_left_r == CNT_W'(1));
      out_done_r   <= (drain_left_r == CNT_W'(1)) && burst_rec_end_r;
    end
  end

  assign out_m.valid         = out_valid_r;
  assign out_m.sample_out    = out_sample_r;
  assign out_m.last_of_burst = out_last_r;
  assign out_m.record_done   = out_done_r;

endmodule

[tb/cmvr_checker.sv]
// Scoreboard for the range clip block: watches the sample, result and register
// channels, predicts every result word and compares it. Depends on cmvr_pkg and cmvr_if.
module cmvr_checker import cmvr_pkg::*; #(
  parameter int MAX_RUN = 32
) (
  input  logic clk,
  input  logic rst_n,
  cmvr_in_if   in_w,
  cmvr_out_if  out_w,
  cmvr_cfg_if  cfg_w,
  output int   mismatches,
  output int   words_pending
);

  typedef struct packed {
    sample_t word;
    logic    last;
    logic    done;
  } clip_word_t;

  // Shadow copy of the registers
  logic [MIN_RUN_W-1:0] min_run;
  sample_t              low_limit;
  sample_t              high_limit;
  sample_t              low_fill;
  sample_t              high_fill;

  // Shadow copy of the run state
  sample_t    held_run [MAX_RUN];
  int         run_len;
  logic       run_open;
  clip_word_t expected_words [$];
  clip_word_t want_word;

  initial mismatches = 0;

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  // Work out the result words caused by one accepted input word
  task automatic predict_clip(input sample_t s, input logic nan, input logic rec_end);
    clip_word_t burst [$];
    int         eff_min;
    logic       is_low;
    sample_t    fill;
    eff_min = (min_run > MAX_RUN) ? MAX_RUN : int'(min_run);
    is_low  = nan || (s < low_limit);
    if (is_low || s > high_limit) begin
      // Clip the word and any short run held in front of it
      fill = is_low ? low_fill : high_fill;
      if (!run_open)
        for (int i = 0; i < run_len && i < MAX_RUN; i++)
          burst.push_back('{fill, 1'b0, 1'b0});
      burst.push_back('{fill, 1'b0, 1'b0});
      run_len  = 0;
      run_open = 1'b0;
    end else if (run_open) begin
      burst.push_back('{s, 1'b0, 1'b0});
    end else if (run_len + 1 >= eff_min) begin
      // Run reached the minimum: release the held words with this one
      for (int i = 0; i < run_len && i < MAX_RUN; i++)
        burst.push_back('{held_run[i], 1'b0, 1'b0});
      burst.push_back('{s, 1'b0, 1'b0});
      run_len  = 0;
      run_open = 1'b1;
    end else begin
      if (run_len < MAX_RUN)
        held_run[run_len] = s;
      run_len++;
    end

    // Flush a short run unchanged at the end of a record
    if (rec_end) begin
      for (int i = 0; i < run_len && i < MAX_RUN; i++)
        burst.push_back('{held_run[i], 1'b0, 1'b0});
      run_len  = 0;
      run_open = 1'b0;
      if (burst.size() > 0)
        burst[burst.size() - 1].done = 1'b1;
    end
    if (burst.size() > 0)
      burst[burst.size() - 1].last = 1'b1;
    foreach (burst[i])
      expected_words.push_back(burst[i]);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      min_run    = '0;
      low_limit  = -16'sd32768;
      high_limit = 16'sd32767;
      low_fill   = '0;
      high_fill  = '0;
      run_len    = 0;
      run_open   = 1'b0;
      expected_words.delete();
    end else begin
      // Compare a result word with the oldest expectation
      if (out_w.valid && out_w.ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("unexpected word %0d", out_w.sample_out));
        end else begin
          want_word = expected_words.pop_front();
          if (out_w.sample_out !== want_word.word)
            report_mismatch($sformatf("sample_out %0d, want %0d",
                                      out_w.sample_out, want_word.word));
          if (out_w.last_of_burst !== want_word.last)
            report_mismatch($sformatf("last_of_burst %b, want %b",
                                      out_w.last_of_burst, want_word.last));
          if (out_w.record_done !== want_word.done)
            report_mismatch($sformatf("record_done %b, want %b",
                                      out_w.record_done, want_word.done));
        end
      end

      // Track register writes
      if (cfg_w.valid && cfg_w.ready) begin
        case (cfg_w.index)
          REG_MIN_RUN:    min_run    = cfg_w.data[MIN_RUN_W-1:0];
          REG_LOW_LIMIT:  low_limit  = sample_t'(cfg_w.data);
          REG_HIGH_LIMIT: high_limit = sample_t'(cfg_w.data);
          REG_LOW_FILL:   low_fill   = sample_t'(cfg_w.data);
          REG_HIGH_FILL:  high_fill  = sample_t'(cfg_w.data);
          default: ;
        endcase
      end

      if (in_w.valid && in_w.ready)
        predict_clip(in_w.sample_in, in_w.not_a_number, in_w.record_end);
    end
    words_pending = expected_words.size();
  end

endmodule

[tb/tb_top.sv]
// Stimulus and verdict for the range clip block: directed words, then random phases
// under several register settings. Depends on cmvr_pkg, cmvr_if and cmvr_checker.
module tb_top;
  import cmvr_pkg::*;

  localparam int MAX_RUN         = 32;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int WORDS_PER_PHASE = 30;

  typedef enum int {RDY_OPEN, RDY_COIN, RDY_SPARSE, RDY_EVERY3} ready_mode_t;
  typedef enum int {END_LOW, END_HIGH, END_NAN, END_NONE, END_RECORD} run_end_t;

  logic        clk;
  logic        rst_n;
  int          cycle_count = 0;
  int          mismatches;
  int          words_pending;
  int          burst_left = 0;
  int          shape_min = 0;
  int          shape_lo = -32768;
  int          shape_hi = 32767;
  ready_mode_t ready_mode = RDY_OPEN;
  int          ready_left = 0;
  int          ready_tick = 0;

  cmvr_in_if  in_w ();
  cmvr_out_if out_w ();
  cmvr_cfg_if cfg_w ();

  clip_with_min_valid_run_core #(.MAX_RUN(MAX_RUN)) u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_s  (in_w),
    .out_m (out_w),
    .cfg_s (cfg_w)
  );

  cmvr_checker #(.MAX_RUN(MAX_RUN)) u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_w          (in_w),
    .out_w         (out_w),
    .cfg_w         (cfg_w),
    .mismatches    (mismatches),
    .words_pending (words_pending)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Receiver stalls: switch at random between stall patterns
  initial out_w.ready = 1'b0;
  always @(negedge clk) begin
    if (ready_left == 0) begin
      ready_mode = ready_mode_t'($urandom_range(0, 3));
      ready_left = $urandom_range(5, 60);
    end
    ready_left--;
    ready_tick++;
    case (ready_mode)
      RDY_OPEN:   out_w.ready <= 1'b1;
      RDY_COIN:   out_w.ready <= ($urandom_range(0, 1) == 1);
      RDY_SPARSE: out_w.ready <= ($urandom_range(0, 3) == 0);
      RDY_EVERY3: out_w.ready <= (ready_tick % 3 == 0);
      default:    out_w.ready <= 1'b1;
    endcase
  end

  // Send one word; open a new burst after a random gap when the last one ran out
  task automatic send_word(input sample_t s, input logic nan, input logic rec_end);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        in_w.valid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    in_w.valid        <= 1'b1;
    in_w.sample_in    <= s;
    in_w.not_a_number <= nan;
    in_w.record_end   <= rec_end;
    do @(posedge clk); while (!in_w.ready);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input cfg_data_t data);
    @(negedge clk);
    cfg_w.valid <= 1'b1;
    cfg_w.index <= idx;
    cfg_w.data  <= data;
    do @(posedge clk); while (!cfg_w.ready);
    @(negedge clk);
    cfg_w.valid <= 1'b0;
  endtask

  // Hold the sender until every expected word is out, then let the block go quiet
  task automatic settle();
    @(negedge clk);
    in_w.valid <= 1'b0;
    while (words_pending != 0)
      @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Write all registers; unused upper bits of the minimum get random values
  task automatic program_regs(input int min_len, input int lo, input int hi,
                              input int lo_fill, input int hi_fill);
    cfg_data_t min_word;
    min_word      = cfg_data_t'($urandom);
    min_word[5:0] = min_len[5:0];
    write_reg(REG_MIN_RUN, min_word);
    write_reg(REG_LOW_LIMIT, cfg_data_t'(lo));
    write_reg(REG_HIGH_LIMIT, cfg_data_t'(hi));
    write_reg(REG_LOW_FILL, cfg_data_t'(lo_fill));
    write_reg(REG_HIGH_FILL, cfg_data_t'(hi_fill));
    shape_min = min_len & 63;
    shape_lo  = lo;
    shape_hi  = hi;
  endtask

  function automatic sample_t in_range_sample();
    if (shape_lo <= shape_hi)
      return sample_t'(shape_lo + int'($urandom_range(shape_hi - shape_lo)));
    return sample_t'($urandom);
  endfunction

  // One run of in-range words of random length, closed by a random kind of end
  task automatic send_run(inout int sent);
    int       eff;
    int       run;
    run_end_t kind;
    eff  = (shape_min > MAX_RUN) ? MAX_RUN : shape_min;
    run  = $urandom_range(eff + 2);
    kind = run_end_t'($urandom_range(0, 4));
    if (kind == END_LOW && shape_lo == -32768)
      kind = END_NAN;
    if (kind == END_HIGH && shape_hi == 32767)
      kind = END_NAN;
    for (int i = 0; i < run; i++) begin
      send_word(in_range_sample(), 1'b0, (kind == END_RECORD) && (i == run - 1));
      sent++;
    end
    case (kind)
      END_LOW: begin
        send_word(sample_t'(-32768 + int'($urandom_range(shape_lo - 1 + 32768))), 1'b0,
                  $urandom_range(0, 7) == 0);
        sent++;
      end
      END_HIGH: begin
        send_word(sample_t'(shape_hi + 1 + int'($urandom_range(32767 - shape_hi - 1))),
                  1'b0, $urandom_range(0, 7) == 0);
        sent++;
      end
      END_NAN: begin
        send_word(sample_t'($urandom), 1'b1, $urandom_range(0, 7) == 0);
        sent++;
      end
      END_RECORD: begin
        if (run == 0) begin
          send_word(sample_t'($urandom), 1'b0, 1'b1);
          sent++;
        end
      end
      default: ;
    endcase
  endtask

  // Mostly well-formed runs, some noise words, an occasional full drain
  task automatic random_phase(input int words);
    int sent;
    sent = 0;
    while (sent < words) begin
      if ($urandom_range(0, 4) == 0) begin
        send_word(sample_t'($urandom), $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0);
        sent++;
      end else begin
        send_run(sent);
      end
      if ($urandom_range(0, 39) == 0)
        settle();
    end
    settle();
  endtask

  initial begin
    in_w.valid        = 1'b0;
    in_w.sample_in    = '0;
    in_w.not_a_number = 1'b0;
    in_w.record_end   = 1'b0;
    cfg_w.valid       = 1'b0;
    cfg_w.index       = REG_MIN_RUN;
    cfg_w.data        = '0;
    rst_n             = 1'b0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // Short runs clipped low and high, limits at their edges, not-a-number
    program_regs(4, -100, 100, -7777, 31420);
    send_word(10, 1'b0, 1'b0);
    send_word(-100, 1'b0, 1'b0);
    send_word(100, 1'b0, 1'b0);
    send_word(-101, 1'b0, 1'b0);
    send_word(5, 1'b0, 1'b0);
    send_word(6, 1'b0, 1'b0);
    send_word(101, 1'b0, 1'b0);
    send_word(0, 1'b1, 1'b0);
    // Run reaches the minimum, then passes until clipped
    send_word(1, 1'b0, 1'b0);
    send_word(2, 1'b0, 1'b0);
    send_word(3, 1'b0, 1'b0);
    send_word(4, 1'b0, 1'b0);
    send_word(32767, 1'b0, 1'b0);
    send_word(-32768, 1'b0, 1'b0);
    // Record end flushes a short run unchanged, or ends on a clipped word
    send_word(20, 1'b0, 1'b0);
    send_word(21, 1'b0, 1'b1);
    send_word(-32768, 1'b0, 1'b1);

    // Lower the minimum while a run is held
    send_word(30, 1'b0, 1'b0);
    send_word(31, 1'b0, 1'b0);
    settle();
    write_reg(REG_MIN_RUN, 16'd1);
    send_word(32, 1'b0, 1'b0);
    send_word(33, 1'b0, 1'b1);

    // Crossed limits: a word both low and high counts as low
    settle();
    program_regs(2, 50, -50, -32768, 32767);
    send_word(0, 1'b0, 1'b0);
    send_word(60, 1'b0, 1'b0);
    send_word(-60, 1'b0, 1'b0);
    send_word(21845, 1'b1, 1'b1);
    settle();

    // Random phases: zero minimum, largest minimum, capped minimum, small, anything
    program_regs(0, -int'($urandom_range(32768)), $urandom_range(32767), $urandom, $urandom);
    random_phase(WORDS_PER_PHASE);
    program_regs(32, -32768, 32767, $urandom, $urandom);
    random_phase(WORDS_PER_PHASE);
    program_regs(63, -1000, 1000, $urandom, $urandom);
    random_phase(WORDS_PER_PHASE);
    program_regs($urandom_range(1, 8), -int'($urandom_range(2000)), $urandom_range(2000),
                 $urandom, $urandom);
    random_phase(WORDS_PER_PHASE);
    program_regs($urandom_range(0, 40), int'($urandom_range(65535)) - 32768,
                 int'($urandom_range(65535)) - 32768, -32768, 32767);
    random_phase(WORDS_PER_PHASE);

    repeat (40) @(negedge clk);
    if (mismatches == 0 && words_pending == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
